// ----- hdl/pil_pkg.sv -----
package pil_pkg;

  // Sequence capacity and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Result status codes.
  localparam logic [1:0] ST_FWD     = 2'd0;
  localparam logic [1:0] ST_REV     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pil_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } pil_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_req;
    logic       insert;
    logic       idx_clear;
    logic       idx_inc;
    logic       idx_dec;
    logic       emit;
    logic [1:0] emit_status;
  } pil_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic pos_bad;
    logic full;
    logic idx_end;
    logic idx_zero;
  } pil_sts_t;

endpackage

// ----- hdl/positional_insert_list_unit.sv -----
// A request is captured on acceptance and then decided. A rejected request shows its single
// result through the output register. An insert that leaves n entries writes the new entry and
// then emits the entries forward and back, 2*n results (up to 2*CAPACITY), one result per cycle
// while the output register is free to take it.
// Reset (synchronous, active high) empties the sequence and idles the controller;
// the entry registers themselves are not cleared.
module positional_insert_list_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pil_pkg::pil_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pil_pkg::pil_out_t out_data
);
  import pil_pkg::*;

  // The controller sequences each request: it captures the request, decides
  // whether it is rejected or inserted, and then walks the index forward and
  // back to emit the whole sequence.
  pil_cmd_t cmd;
  pil_sts_t sts;

  pil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the entries, the count, the walk index and the output
  // register. The output register lets a new request be accepted while the
  // final result of the previous one still waits downstream.
  pil_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // A rejected result is always a single, final result with a zero element.
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_INVALID || out_data.status == ST_FULL)
    |-> out_data.last && (out_data.element == '0))
    else $error("rejected result is not final or has a nonzero element");

  // The forward pass never carries the final mark.
  a_fwd_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FWD) |-> !out_data.last)
    else $error("forward result marked last");

  // After a request is taken, the block is busy with it in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in progress");
`endif

endmodule

// ----- hdl/pil_ctrl.sv -----
module pil_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pil_pkg::pil_sts_t sts,
  output pil_pkg::pil_cmd_t cmd
);
  import pil_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_FWD    = 2'd2;
  localparam logic [1:0] S_REV    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.pos_bad || sts.full) begin
          // A rejected request gives a single result once the output is free.
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.pos_bad ? ST_INVALID : ST_FULL;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.insert    = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_FWD;
        end
      end
      S_FWD: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FWD;
          // The reverse pass starts at the same back entry.
          if (sts.idx_end) begin
            state_next = S_REV;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_REV: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_REV;
          if (sts.idx_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/pil_dp.sv -----
module pil_dp (
  input  logic              clk,
  input  logic              rst,
  input  pil_pkg::pil_in_t  in_data,
  input  pil_pkg::pil_cmd_t cmd,
  output pil_pkg::pil_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output pil_pkg::pil_out_t out_data
);
  import pil_pkg::*;

  logic [POS_W-1:0]         req_pos;
  logic signed [DATA_W-1:0] req_val;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         idx;
  logic signed [DATA_W-1:0] store [CAPACITY];
  logic [CMP_W-1:0]         pos_ext;
  logic signed [DATA_W-1:0] rd_data;
  logic                     is_reject;

  assign pos_ext = CMP_W'(req_pos);
  assign rd_data = store[idx];

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.pos_bad   = pos_ext > CMP_W'(count);
  assign sts.full      = count == CNT_W'(CAPACITY);
  assign sts.idx_end   = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign sts.idx_zero  = idx == '0;

  assign is_reject = (cmd.emit_status == ST_INVALID) || (cmd.emit_status == ST_FULL);

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_pos <= in_data.position;
      req_val <= in_data.value;
    end
  end

  // Every entry at or above the insert point moves up by one, all together with the write of the new value.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (pos_ext == '0) begin
        store[0] <= req_val;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (CMP_W'(i) == pos_ext) begin
          store[i] <= req_val;
        end else if (CMP_W'(i) > pos_ext) begin
          store[i] <= store[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end else if (cmd.idx_dec) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status  <= cmd.emit_status;
      out_data.element <= is_reject ? '0 : rd_data;
      out_data.last    <= is_reject || ((cmd.emit_status == ST_REV) && (idx == '0));
    end
  end

endmodule
